[src/lra_pkg.sv]
// Shared types and constants for the line request assembler.
// Used by lra_ctrl, lra_dp and line_request_assembler; no dependencies.
`default_nettype none

package lra_pkg;

    // line bookkeeping widths
    localparam int unsigned COUNT_W    = 9;
    localparam int unsigned WORD_IDX_W = 6;

    // line terminators
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_NUL = 8'h00;

    // keyword lines, first byte in the lowest bits
    localparam logic [39:0]        LINE_BEGIN = 40'h4E_49_47_45_42;
    localparam logic [23:0]        LINE_END   = 24'h44_4E_45;
    localparam logic [COUNT_W-1:0] BEGIN_LEN  = 9'd5;
    localparam logic [COUNT_W-1:0] END_LEN    = 9'd3;

    typedef logic [1:0] kind_t;

    // result kinds
    localparam kind_t KIND_FINAL   = 2'd0;
    localparam kind_t KIND_CONT    = 2'd1;
    localparam kind_t KIND_END     = 2'd2;
    localparam kind_t KIND_TOOLONG = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic  accept;
        logic  store_byte;
        logic  clear_line;
        logic  set_mode;
        logic  set_done;
        logic  start_emit;
        kind_t emit_kind;
        logic  emit_blank;
        logic  issue_read;
        logic  load_out;
        logic  next_word;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic term;
        logic is_begin;
        logic is_end;
        logic full;
        logic mode;
        logic done;
        logic last_word;
    } status_t;

endpackage

`default_nettype wire

[src/lra_ctrl.sv]
// Controller state machine for the line request assembler.
// Depends on lra_pkg for the command and status structs and result kinds.
`default_nettype none

module lra_ctrl
    import lra_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // byte decisions and word emission sequencing
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_RUN);
        case (state_reg)
            S_RUN:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!status.done)
                    begin
                        if (status.term)
                        begin
                            if (status.mode)
                            begin
                                cmd.start_emit = 1'b1;
                                if (status.is_end)
                                begin
                                    cmd.emit_kind  = KIND_END;
                                    cmd.emit_blank = 1'b1;
                                    cmd.set_done   = 1'b1;
                                end
                                else
                                begin
                                    cmd.emit_kind = KIND_CONT;
                                end
                            end
                            else if (status.is_begin)
                            begin
                                cmd.set_mode   = 1'b1;
                                cmd.clear_line = 1'b1;
                            end
                            else
                            begin
                                cmd.start_emit = 1'b1;
                                cmd.emit_kind  = KIND_FINAL;
                                cmd.set_done   = 1'b1;
                            end
                        end
                        else if (status.full)
                        begin
                            cmd.start_emit = 1'b1;
                            cmd.emit_kind  = KIND_TOOLONG;
                            cmd.emit_blank = 1'b1;
                            cmd.set_done   = 1'b1;
                        end
                        else
                        begin
                            cmd.store_byte = 1'b1;
                        end
                    end
                    if (cmd.start_emit)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.issue_read = 1'b1;
                state_next     = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (status.last_word)
                    begin
                        cmd.clear_line = 1'b1;
                        state_next     = S_RUN;
                    end
                    else
                    begin
                        cmd.next_word = 1'b1;
                        state_next    = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    // output slot occupancy
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a word is only loaded into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("word loaded over an untaken result");

    // emission only starts from an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_emit |-> (in_valid && in_ready))
        else $error("emission started without an input transaction");

    // the last word of a run hands control back to byte intake
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && status.last_word) |=> in_ready)
        else $error("input not reopened after last word");

endmodule

`default_nettype wire

[src/lra_dp.sv]
// Datapath for the line request assembler: word assembly, row memory,
// line bookkeeping and output registers. Depends on lra_pkg.
`default_nettype none

module lra_dp
    import lra_pkg::*;
#(
    parameter int unsigned MAX_LINE = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  data_byte,
    input  wire logic        new_connection,
    input  wire cmd_t        cmd,
    output status_t          status,
    output logic [1:0]       kind,
    output logic [63:0]      word_data,
    output logic [3:0]       bytes_in_word,
    output logic [8:0]       line_length,
    output logic             last_word
);

    localparam int unsigned ROWS  = (MAX_LINE + 7) / 8;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_LINE);

    // line state
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [63:0]           acc_reg;
    logic [63:0]           acc_next;
    logic                  mode_reg;
    logic                  mode_next;
    logic                  done_reg;
    logic                  done_next;

    // emission state
    kind_t                 kind_reg;
    logic                  blank_reg;
    logic [WORD_IDX_W-1:0] word_idx_reg;
    logic [63:0]           rd_data_reg;

    // output registers
    kind_t                 out_kind_reg;
    logic [63:0]           out_data_reg;
    logic [3:0]            out_nbytes_reg;
    logic [COUNT_W-1:0]    out_len_reg;
    logic                  out_last_reg;

    // full 8-byte rows of the current line
    logic [63:0]           line_mem [ROWS];

    logic [COUNT_W-1:0]    eff_count;
    logic [63:0]           eff_acc;
    logic [2:0]            pos;
    logic [63:0]           acc_ins;
    logic [WORD_IDX_W-1:0] eff_row;
    logic                  row_wr;
    logic [WORD_IDX_W-1:0] full_rows;
    logic                  part_word;
    logic [WORD_IDX_W-1:0] words;
    logic                  from_mem;

    // a new connection wipes the line before this byte is looked at
    assign eff_count = new_connection ? '0 : count_reg;
    assign eff_acc   = new_connection ? '0 : acc_reg;

    // byte classification and keyword match
    assign status.term     = (data_byte == BYTE_CR) || (data_byte == BYTE_LF)
                             || (data_byte == BYTE_NUL);
    assign status.is_begin = (eff_count == BEGIN_LEN) && (eff_acc[39:0] == LINE_BEGIN);
    assign status.is_end   = (eff_count == END_LEN) && (eff_acc[23:0] == LINE_END);
    assign status.full     = (eff_count >= MAX_CNT);
    assign status.mode     = new_connection ? 1'b0 : mode_reg;
    assign status.done     = new_connection ? 1'b0 : done_reg;

    // byte insertion into the partial word
    assign pos     = eff_count[2:0];
    assign acc_ins = eff_acc | ({56'b0, data_byte} << {pos, 3'b000});
    assign eff_row = eff_count[COUNT_W-1:3];
    assign row_wr  = cmd.store_byte && (pos == 3'd7);

    // word count of the line being emitted
    assign full_rows = count_reg[COUNT_W-1:3];
    assign part_word = (count_reg[2:0] != 3'd0) || (count_reg == '0);
    assign words     = full_rows + {{(WORD_IDX_W-1){1'b0}}, part_word};
    assign from_mem  = (word_idx_reg < full_rows);
    assign status.last_word = blank_reg || (word_idx_reg == (words - 6'd1));

    // next line state
    always_comb
    begin
        count_next = count_reg;
        acc_next   = acc_reg;
        mode_next  = mode_reg;
        done_next  = done_reg;
        if (cmd.accept && new_connection)
        begin
            count_next = '0;
            acc_next   = '0;
            mode_next  = 1'b0;
            done_next  = 1'b0;
        end
        if (cmd.store_byte)
        begin
            count_next = eff_count + 9'd1;
            acc_next   = row_wr ? 64'd0 : acc_ins;
        end
        if (cmd.clear_line)
        begin
            count_next = '0;
            acc_next   = '0;
        end
        if (cmd.set_mode)
        begin
            mode_next = 1'b1;
        end
        if (cmd.set_done)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            acc_reg      <= '0;
            mode_reg     <= 1'b0;
            done_reg     <= 1'b0;
            word_idx_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            acc_reg   <= acc_next;
            mode_reg  <= mode_next;
            done_reg  <= done_next;
            if (cmd.start_emit)
            begin
                word_idx_reg <= '0;
            end
            else if (cmd.next_word)
            begin
                word_idx_reg <= word_idx_reg + 6'd1;
            end
        end
    end

    // row memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (row_wr)
        begin
            line_mem[eff_row[ROW_W-1:0]] <= acc_ins;
        end
        if (cmd.issue_read)
        begin
            rd_data_reg <= line_mem[word_idx_reg[ROW_W-1:0]];
        end
    end

    // emission attributes and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.start_emit)
        begin
            kind_reg  <= cmd.emit_kind;
            blank_reg <= cmd.emit_blank;
        end
        if (cmd.load_out)
        begin
            out_kind_reg <= kind_reg;
            out_last_reg <= status.last_word;
            if (blank_reg)
            begin
                out_data_reg   <= '0;
                out_nbytes_reg <= 4'd0;
                out_len_reg    <= '0;
            end
            else
            begin
                out_data_reg   <= from_mem ? rd_data_reg : acc_reg;
                out_nbytes_reg <= from_mem ? 4'd8 : {1'b0, count_reg[2:0]};
                out_len_reg    <= count_reg;
            end
        end
    end

    assign kind          = out_kind_reg;
    assign word_data     = out_data_reg;
    assign bytes_in_word = out_nbytes_reg;
    assign line_length   = out_len_reg;
    assign last_word     = out_last_reg;

    // line never grows beyond the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("line count beyond buffer size");

    // partial word holds zeros above the bytes taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg >> {count_reg[2:0], 3'b000}) == 64'd0)
        else $error("stale bytes in partial word");

    // reads never go past the partial word of the line
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue_read |-> (word_idx_reg <= full_rows))
        else $error("row read beyond the current line");

endmodule

`default_nettype wire

[src/line_request_assembler.sv]
// Line request assembler: takes one byte per transaction and emits packed
// line words. Depends on lra_pkg, lra_ctrl and lra_dp.
//
// Bytes are taken one per cycle while no line is being emitted. A CR, LF
// or NUL ends the line; a line of BEGIN enters multiline mode without any
// output, after which lines come out as continuations until a line of END,
// which gives a single end result. Outside multiline mode a line comes out
// as a final request. A line of n bytes comes out as max(1, ceil(n/8))
// words, first byte in the low bits, the last one marked; a byte other than
// a terminator arriving with MAX_LINE bytes already held gives a single
// too-long result. After a final, end or too-long result bytes are dropped
// until one arrives with new_connection set. While a line is emitted the
// input is stalled: each word passes through a registered read of the
// 8-byte row memory and then the load of the output register, which waits
// for a free output slot under back-pressure. The row memory needs no
// clearing after reset.
`default_nettype none

module line_request_assembler
    import lra_pkg::*;
#(
    parameter int unsigned MAX_LINE = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        new_connection,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [63:0]      word_data,
    output logic [3:0]       bytes_in_word,
    output logic [8:0]       line_length,
    output logic             last_word
);

    cmd_t    cmd;
    status_t status;

    // sequencing
    lra_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // line buffer and output words
    lra_dp #(
        .MAX_LINE (MAX_LINE)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .new_connection (new_connection),
        .cmd            (cmd),
        .status         (status),
        .kind           (kind),
        .word_data      (word_data),
        .bytes_in_word  (bytes_in_word),
        .line_length    (line_length),
        .last_word      (last_word)
    );

endmodule

`default_nettype wire
